// ----- hw/rtl/bpc_pkg.sv -----
package bpc_pkg;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PRESSED  = 3'd1;
    localparam logic [2:0] EV_RELEASED = 3'd2;
    localparam logic [2:0] EV_SHORT    = 3'd3;
    localparam logic [2:0] EV_LONG     = 3'd4;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_EDGE_MODE  = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic        edge_mode_enable;
    } bpc_cfg_t;

    // one queued item: one or two result words that share button, duration and total
    typedef struct packed {
        logic        button;
        logic [2:0]  code0;
        logic [2:0]  code1;
        logic        two;
        logic [31:0] duration;
        logic [31:0] total;
    } bpc_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } bpc_qstat_t;

endpackage

// ----- hw/rtl/bpc_front.sv -----
module bpc_front
    import bpc_pkg::*;
#(
    parameter int NUM_BUTTONS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  bpc_cfg_t    cfg,
    input  logic        in_valid,
    input  logic [1:0]  op,
    input  logic        button,
    input  logic [31:0] time_ms,
    input  logic        level_pressed,
    input  bpc_qstat_t  qstat,
    output logic        push,
    output bpc_entry_t  entry
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic        is_pressed_reg       [NUM_BUTTONS];
    logic        long_reported_reg    [NUM_BUTTONS];
    logic [31:0] press_start_reg      [NUM_BUTTONS];
    logic [31:0] held_time_reg        [NUM_BUTTONS];
    logic [31:0] press_counter_reg    [NUM_BUTTONS];
    logic [31:0] edge_change_time_reg [NUM_BUTTONS];
    logic [31:0] poll_change_time_reg [NUM_BUTTONS];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             accept;

    logic        cur_pressed;
    logic        cur_long;
    logic [31:0] cur_start;
    logic [31:0] cur_held;
    logic [31:0] cur_count;
    logic [31:0] cur_ect;
    logic [31:0] cur_pct;

    logic [31:0] since_press;
    logic [31:0] since_edge;
    logic [31:0] since_poll;
    logic        past_long;

    logic        wr_en;
    logic        pressed_next;
    logic        long_next;
    logic [31:0] start_next;
    logic [31:0] held_next;
    logic [31:0] count_next;
    logic [31:0] ect_next;
    logic [31:0] pct_next;

    assign idx      = IDX_W'(button);
    assign in_range = 7'(button) < 7'(NUM_BUTTONS);
    assign accept   = in_valid && !qstat.full;

    always_comb
    begin
        cur_pressed = 1'b0;
        cur_long    = 1'b0;
        cur_start   = '0;
        cur_held    = '0;
        cur_count   = '0;
        cur_ect     = '0;
        cur_pct     = '0;
        if (in_range)
        begin
            cur_pressed = is_pressed_reg[idx];
            cur_long    = long_reported_reg[idx];
            cur_start   = press_start_reg[idx];
            cur_held    = held_time_reg[idx];
            cur_count   = press_counter_reg[idx];
            cur_ect     = edge_change_time_reg[idx];
            cur_pct     = poll_change_time_reg[idx];
        end
    end

    assign since_press = time_ms - cur_start;
    assign since_edge  = time_ms - cur_ect;
    assign since_poll  = time_ms - cur_pct;
    assign past_long   = since_press >= 32'(cfg.long_press_ms);

    always_comb
    begin
        wr_en        = 1'b0;
        push         = 1'b0;
        pressed_next = cur_pressed;
        long_next    = cur_long;
        start_next   = cur_start;
        held_next    = cur_held;
        count_next   = cur_count;
        ect_next     = cur_ect;
        pct_next     = cur_pct;
        entry.button = button;
        entry.code0  = EV_NONE;
        entry.code1  = EV_NONE;
        entry.two    = 1'b0;

        if (!in_range)
        begin
            push = accept && (op == OP_POLL);
        end
        else
        begin
            case (op)
                OP_EDGE:
                begin
                    if (cfg.edge_mode_enable && (level_pressed != cur_pressed)
                        && (since_edge >= 32'(cfg.debounce_ms)))
                    begin
                        wr_en        = accept;
                        push         = accept;
                        ect_next     = time_ms;
                        pressed_next = level_pressed;
                        if (level_pressed)
                        begin
                            start_next  = time_ms;
                            count_next  = cur_count + 32'd1;
                            long_next   = 1'b0;
                            entry.code0 = EV_PRESSED;
                        end
                        else
                        begin
                            held_next   = since_press;
                            entry.code0 = EV_RELEASED;
                            if (past_long)
                            begin
                                if (!cur_long)
                                begin
                                    long_next   = 1'b1;
                                    entry.two   = 1'b1;
                                    entry.code1 = EV_LONG;
                                end
                            end
                            else
                            begin
                                entry.two   = 1'b1;
                                entry.code1 = EV_SHORT;
                            end
                        end
                    end
                end
                OP_POLL:
                begin
                    push  = accept;
                    wr_en = accept;
                    if (since_poll >= 32'(cfg.debounce_ms))
                    begin
                        if (level_pressed != cur_pressed)
                        begin
                            pct_next     = time_ms;
                            pressed_next = level_pressed;
                            if (level_pressed)
                            begin
                                start_next  = time_ms;
                                count_next  = cur_count + 32'd1;
                                long_next   = 1'b0;
                                entry.code0 = EV_PRESSED;
                            end
                            else
                            begin
                                held_next   = since_press;
                                entry.code0 = EV_RELEASED;
                            end
                        end
                        else if (level_pressed && !cur_long && past_long)
                        begin
                            long_next   = 1'b1;
                            entry.code0 = EV_LONG;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    wr_en      = accept;
                    count_next = '0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end

        // out-of-range polls see zeros through the cur_* defaults
        entry.duration = held_next;
        entry.total    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                is_pressed_reg[i]       <= 1'b0;
                long_reported_reg[i]    <= 1'b0;
                press_start_reg[i]      <= '0;
                held_time_reg[i]        <= '0;
                press_counter_reg[i]    <= '0;
                edge_change_time_reg[i] <= '0;
                poll_change_time_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            is_pressed_reg[idx]       <= pressed_next;
            long_reported_reg[idx]    <= long_next;
            press_start_reg[idx]      <= start_next;
            held_time_reg[idx]        <= held_next;
            press_counter_reg[idx]    <= count_next;
            edge_change_time_reg[idx] <= ect_next;
            poll_change_time_reg[idx] <= pct_next;
        end
    end

endmodule

// ----- hw/rtl/bpc_queue.sv -----
module bpc_queue
    import bpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bpc_entry_t push_entry,
    input  logic       pop,
    output bpc_entry_t head,
    output bpc_qstat_t qstat
);

    bpc_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/bpc_back.sv -----
module bpc_back
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bpc_entry_t  head,
    input  bpc_qstat_t  qstat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        button_out,
    output logic [2:0]  event_code,
    output logic [31:0] duration_ms,
    output logic [31:0] press_total,
    output logic        last
);

    // 0: first word of the head entry, 1: its second word
    logic phase_reg;
    logic phase_next;
    logic take;

    assign out_valid   = !qstat.empty;
    assign button_out  = head.button;
    assign event_code  = phase_reg ? head.code1 : head.code0;
    assign duration_ms = head.duration;
    assign press_total = head.total;
    assign last        = phase_reg || !head.two;

    assign take = out_valid && !out_stall;
    assign pop  = take && last;

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- hw/rtl/button_press_classifier.sv -----
// Button press classifier: tracks press state, debounce and long presses per button.
// Each input word (edge event, poll sample or press-count clear) is taken when
// the four-entry result queue has room; the front end evaluates it against the
// per-button state and updates that state at the same edge, so words may arrive
// on every cycle while the queue is not full. The back end drains the queue one
// result word per cycle while out_stall is low: a release edge gives two words
// (RELEASED, then SHORT or LONG) unless its long press was already reported, all
// others one or none. With out_stall low, sustained rate is one input per cycle
// for single-result items; the single output port limits two-word release edges.
// Config writes are always ready and must be issued only while the block is idle.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int NUM_BUTTONS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic        button,
    input  logic [31:0] time_ms,
    input  logic        level_pressed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        button_out,
    output logic [2:0]  event_code,
    output logic [31:0] duration_ms,
    output logic [31:0] press_total,
    output logic        last
);

    bpc_cfg_t   cfg_reg;
    bpc_cfg_t   cfg_next;
    bpc_qstat_t qstat;
    bpc_entry_t push_entry;
    bpc_entry_t head;
    logic       push;
    logic       pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = qstat.full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   cfg_next.debounce_ms      = cfg_data;
                REG_LONG_PRESS: cfg_next.long_press_ms    = cfg_data;
                REG_EDGE_MODE:  cfg_next.edge_mode_enable = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.edge_mode_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpc_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .op            (op),
        .button        (button),
        .time_ms       (time_ms),
        .level_pressed (level_pressed),
        .qstat         (qstat),
        .push          (push),
        .entry         (push_entry)
    );

    bpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    bpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .button_out  (button_out),
        .event_code  (event_code),
        .duration_ms (duration_ms),
        .press_total (press_total),
        .last        (last)
    );

endmodule

// ----- test/button_press_classifier_tb.sv -----
`timescale 1ns / 1ps

module button_press_classifier_tb;
    import bpc_pkg::*;

    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_WORDS = 100;
    localparam int NUM_PHASES = 8;
    localparam int SCRIPT_LEN = 30;
    localparam int MAX_REPORTS = 20;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_DEBOUNCE;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_POLL;
    logic        button = 1'b0;
    logic [31:0] time_ms = 32'd0;
    logic        level_pressed = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        button_out;
    logic [2:0]  event_code;
    logic [31:0] duration_ms;
    logic [31:0] press_total;
    logic        last;

    button_press_classifier #(.NUM_BUTTONS(2)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .button(button),
        .time_ms(time_ms),
        .level_pressed(level_pressed),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .button_out(button_out),
        .event_code(event_code),
        .duration_ms(duration_ms),
        .press_total(press_total),
        .last(last)
    );

    typedef struct packed {
        logic        button;
        logic [2:0]  code;
        logic [31:0] dur;
        logic [31:0] total;
        logic        last;
    } press_event_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // sel is the op for a word row, the register index for a cfg row;
    // val is the timestamp or the register data
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic        btn;
        logic [31:0] val;
        logic        lvl;
        logic        typed;
        logic [1:0]  nres;
        logic [2:0]  c0;
        logic [2:0]  c1;
    } script_row_t;

    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_WORD, OP_EDGE,  1'b0, 32'd100,       1'b1, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd10,        1'b0, 1'b1, 2'd1, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd60,        1'b1, 1'b1, 2'd1, EV_PRESSED, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd70,        1'b1, 1'b1, 2'd1, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd2000,      1'b1, 1'b1, 2'd1, EV_LONG, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd3000,      1'b1, 1'b1, 2'd1, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd3100,      1'b0, 1'b1, 2'd1, EV_RELEASED, EV_NONE},
        '{ROW_WORD, OP_CLEAR, 1'b0, 32'd0,         1'b0, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_UNDEF, 1'b1, 32'd0,         1'b1, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 2'd1, EV_NONE, EV_NONE},
        '{ROW_CFG,  REG_EDGE_MODE, 1'b0, 32'd1,    1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'd16,        1'b1, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'd100,       1'b0, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'd100,       1'b1, 1'b1, 2'd1, EV_PRESSED, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'd120,       1'b0, 1'b1, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'd300,       1'b0, 1'b1, 2'd2, EV_RELEASED, EV_SHORT},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'hFFFF_FFF0, 1'b1, 1'b1, 2'd1, EV_PRESSED, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'h0000_0500, 1'b0, 1'b1, 2'd2, EV_RELEASED, EV_LONG},
        '{ROW_WORD, OP_EDGE,  1'b0, 32'd5000,      1'b1, 1'b1, 2'd1, EV_PRESSED, EV_NONE},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd7000,      1'b1, 1'b1, 2'd1, EV_LONG, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b0, 32'd8000,      1'b0, 1'b1, 2'd1, EV_RELEASED, EV_NONE},
        '{ROW_CFG,  REG_DEBOUNCE,   1'b0, 32'd0,   1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_CFG,  REG_LONG_PRESS, 1'b0, 32'd0,   1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b0, 32'd8000,      1'b1, 1'b1, 2'd1, EV_PRESSED, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b0, 32'd8000,      1'b0, 1'b1, 2'd2, EV_RELEASED, EV_LONG},
        '{ROW_WORD, OP_POLL,  1'b0, 32'd8000,      1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_CFG,  REG_DEBOUNCE,   1'b0, 32'hFFFF, 1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_CFG,  REG_LONG_PRESS, 1'b0, 32'hFFFF, 1'b0, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'h0001_0000, 1'b1, 1'b0, 2'd0, EV_NONE, EV_NONE},
        '{ROW_WORD, OP_EDGE,  1'b1, 32'h0002_0000, 1'b1, 1'b0, 2'd0, EV_NONE, EV_NONE}
    };

    // predictor copy of the block
    logic [15:0] cur_debounce;
    logic [15:0] cur_long;
    logic        cur_edge;
    logic        pressed_now [2];
    logic        long_seen [2];
    logic [31:0] start_ms [2];
    logic [31:0] hold_ms [2];
    logic [31:0] presses [2];
    logic [31:0] edge_seen_ms [2];
    logic [31:0] poll_seen_ms [2];

    press_event_t pending_events [$];
    press_event_t got_ev;
    press_event_t want_ev;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int longs_seen = 0;
    int shorts_seen = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_ev = {button_out, event_code, duration_ms, press_total, last};
            results_checked++;
            if (event_code == EV_LONG)
                longs_seen++;
            if (event_code == EV_SHORT)
                shorts_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word btn=%0d code=%0d dur=%0d total=%0d last=%0d",
                             $time, got_ev.button, got_ev.code, got_ev.dur, got_ev.total,
                             got_ev.last);
            end else begin
                want_ev = pending_events.pop_front();
                if (want_ev !== got_ev) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected btn=%0d code=%0d dur=%0d total=%0d last=%0d",
                                 $time, want_ev.button, want_ev.code, want_ev.dur,
                                 want_ev.total, want_ev.last);
                        $display("%0t:   actual btn=%0d code=%0d dur=%0d total=%0d last=%0d",
                                 $time, got_ev.button, got_ev.code, got_ev.dur,
                                 got_ev.total, got_ev.last);
                    end
                end
            end
        end
    end

    task automatic reset_model();
        cur_debounce = DEBOUNCE_RST;
        cur_long = LONG_PRESS_RST;
        cur_edge = 1'b0;
        for (int i = 0; i < 2; i++) begin
            pressed_now[i] = 1'b0;
            long_seen[i] = 1'b0;
            start_ms[i] = 32'd0;
            hold_ms[i] = 32'd0;
            presses[i] = 32'd0;
            edge_seen_ms[i] = 32'd0;
            poll_seen_ms[i] = 32'd0;
        end
    endtask

    function automatic logic [2:0] take_change(input logic b, input logic [31:0] t,
                                               input logic lvl);
        pressed_now[b] = lvl;
        if (lvl) begin
            start_ms[b] = t;
            presses[b] = presses[b] + 32'd1;
            long_seen[b] = 1'b0;
            return EV_PRESSED;
        end
        hold_ms[b] = t - start_ms[b];
        return EV_RELEASED;
    endfunction

    // classifies one word and updates the press state; returns the codes emitted
    task automatic classify_word(input logic [1:0] w_op, input logic b,
                                 input logic [31:0] t, input logic lvl,
                                 output int n, output logic [2:0] c0, output logic [2:0] c1);
        logic [31:0] gap;
        logic [31:0] held_for;
        n = 0;
        c0 = EV_NONE;
        c1 = EV_NONE;
        if (w_op == OP_EDGE) begin
            gap = t - edge_seen_ms[b];
            if (cur_edge && lvl != pressed_now[b] && gap >= {16'd0, cur_debounce}) begin
                edge_seen_ms[b] = t;
                c0 = take_change(b, t, lvl);
                n = 1;
                if (c0 == EV_RELEASED && !(hold_ms[b] >= {16'd0, cur_long} && long_seen[b]))
                begin
                    n = 2;
                    if (hold_ms[b] >= {16'd0, cur_long}) begin
                        long_seen[b] = 1'b1;
                        c1 = EV_LONG;
                    end else begin
                        c1 = EV_SHORT;
                    end
                end
            end
        end else if (w_op == OP_POLL) begin
            n = 1;
            gap = t - poll_seen_ms[b];
            held_for = t - start_ms[b];
            if (gap >= {16'd0, cur_debounce}) begin
                if (lvl != pressed_now[b]) begin
                    poll_seen_ms[b] = t;
                    c0 = take_change(b, t, lvl);
                end else if (lvl && !long_seen[b] && held_for >= {16'd0, cur_long}) begin
                    long_seen[b] = 1'b1;
                    c0 = EV_LONG;
                end
            end
        end else if (w_op == OP_CLEAR) begin
            presses[b] = 32'd0;
        end
    endtask

    // starts and ends at a falling edge; leaves in_valid high for a following word
    task automatic send_word(input logic [1:0] w_op, input logic b, input logic [31:0] t,
                             input logic lvl, input logic typed, input int nres,
                             input logic [2:0] tc0, input logic [2:0] tc1);
        int n;
        logic [2:0] c0;
        logic [2:0] c1;
        press_event_t ev;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = w_op;
        button = b;
        time_ms = t;
        level_pressed = lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        classify_word(w_op, b, t, lvl, n, c0, c1);
        if (typed) begin
            n = nres;
            c0 = tc0;
            c1 = tc1;
        end
        // every word of one item carries the stored duration and count after the step
        for (int k = 0; k < n; k++) begin
            ev.button = b;
            ev.code = (k == 0) ? c0 : c1;
            ev.dur = hold_ms[b];
            ev.total = presses[b];
            ev.last = (k == n - 1);
            pending_events.push_back(ev);
        end
        words_sent++;
        @(negedge clk);
    endtask

    // only while idle: drains results, lets the pipe settle, then writes
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_DEBOUNCE:   cur_debounce = data;
            REG_LONG_PRESS: cur_long = data;
            REG_EDGE_MODE:  cur_edge = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int counted;
        int r;
        int unsigned span;
        logic [31:0] clock_ms;
        logic [1:0] w_op;
        logic w_btn;
        logic [31:0] w_t;
        logic w_lvl;
        logic [15:0] deb;
        logic [15:0] lng;
        logic edg;

        reset_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG)
                write_reg(script[i].sel, script[i].val[15:0]);
            else
                send_word(script[i].sel, script[i].btn, script[i].val, script[i].lvl,
                          script[i].typed, int'(script[i].nres), script[i].c0,
                          script[i].c1);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) begin
                deb = 16'd0;
                lng = 16'd0;
                edg = 1'b1;
            end else if (p == 1) begin
                deb = 16'hFFFF;
                lng = 16'hFFFF;
                edg = 1'b1;
            end else begin
                deb = 16'($urandom_range(200));
                lng = 16'($urandom_range(3000));
                edg = (p == 3) ? 1'b0 : ($urandom_range(3) != 0);
            end
            write_reg(REG_DEBOUNCE, deb);
            write_reg(REG_LONG_PRESS, lng);
            write_reg(REG_EDGE_MODE, {15'd0, edg});
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 49; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 49; end
                default: begin send_gap_pct = 13; stall_pct = 13; end
            endcase

            clock_ms = $urandom;
            span = cur_debounce + cur_long + 1;
            counted = 0;
            while (counted < PHASE_WORDS) begin
                r = $urandom_range(99);
                w_btn = 1'($urandom_range(1));
                if (r < 8) begin
                    // noise: any op, any time
                    w_op = 2'($urandom_range(3));
                    w_t = $urandom;
                    w_lvl = 1'($urandom_range(1));
                end else begin
                    r = $urandom_range(99);
                    w_op = (r < 46) ? OP_EDGE : (r < 92) ? OP_POLL : OP_CLEAR;
                    clock_ms = clock_ms + $urandom_range(span + span / 2);
                    w_t = clock_ms;
                    // polls at the held level are what find long presses
                    if (w_op == OP_POLL)
                        w_lvl = ($urandom_range(1) == 0) ? pressed_now[w_btn]
                                                         : !pressed_now[w_btn];
                    else
                        w_lvl = ($urandom_range(4) == 0) ? pressed_now[w_btn]
                                                         : !pressed_now[w_btn];
                end
                counted++;
                send_word(w_op, w_btn, w_t, w_lvl, 1'b0, 0, EV_NONE, EV_NONE);
            end
        end

        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words over %0d config phases plus a directed script",
                 words_sent, NUM_PHASES);
        $display("Checked %0d result words: %0d long presses, %0d short presses",
                 results_checked, longs_seen, shorts_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- button_press_classifier.f -----
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_queue.sv
hw/rtl/bpc_back.sv
hw/rtl/button_press_classifier.sv
test/button_press_classifier_tb.sv
